FILE: rtl/ftt_pkg.sv
// ----------------------------------------------------------------------------
// ftt_pkg
// shared types and constants for the frame deadline timer table
// ----------------------------------------------------------------------------
package ftt_pkg;

    localparam int FN_W    = 22;
    localparam int OFS_W   = 16;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 4;
    localparam int IDX_W   = 8;   // wide enough for the largest table
    localparam int CNT_W   = 9;
    localparam int CNT_OUT_W = 5;
    localparam logic [FN_W-1:0] FN_MAX = {FN_W{1'b1}};

    localparam int S_DATA_W = 48;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 40;

    typedef enum logic [2:0] {
        REQ_SCHEDULE = 3'd0,
        REQ_CANCEL   = 3'd1,
        REQ_PENDING  = 3'd2,
        REQ_NEAREST  = 3'd3,
        REQ_FIRE     = 3'd4,
        REQ_COUNT    = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        WM_NEAREST = 2'd0,
        WM_FIRE    = 2'd1,
        WM_COUNT   = 2'd2
    } wave_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    // search token passed from cell to cell
    typedef struct packed {
        logic                go;
        wave_mode_t          mode;
        logic [FN_W-1:0]     cur;
        logic                found;
        logic [FN_W-1:0]     deadline;
        logic [STAMP_W-1:0]  stamp;
        logic [IDX_W-1:0]    idx;
        logic [CNT_W-1:0]    cnt;
    } wave_t;

    // write and clear broadcast to all cells
    typedef struct packed {
        logic                we;
        logic                clr;
        logic [IDX_W-1:0]    idx;
        logic [IDX_W-1:0]    clr_idx;
        logic [FN_W-1:0]     deadline;
        logic [STAMP_W-1:0]  stamp;
    } wr_t;

endpackage

FILE: rtl/frame_deadline_timer_table.sv
// ----------------------------------------------------------------------------
// frame_deadline_timer_table
// timer slots keyed by frame deadline, searched by a token along a row of cells
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  s_tuser req_type, s_tdata slot..frame_now
//  m_*      out        m_tvalid/m_tready  m_tdata result fields, m_tlast last
//
//  schedule, cancel and pending are served without a search; pending registers
//  its result directly. nearest and count send a search token down the row and
//  load their result once it leaves the last cell: the token crosses one cell
//  per cycle. fire runs one pass per fired slot plus a final empty pass.
//  requests are taken only when idle with the output register empty;
//  a stalled output holds the sequencer. reset clears all active bits at once.
// ----------------------------------------------------------------------------
module frame_deadline_timer_table #(
    parameter int TIMERS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // slot[3:0], offset[19:4], frame_now[41:20], zero fill
    input  logic [ftt_pkg::S_DATA_W-1:0]   s_tdata,
    // req_type[2:0]
    input  logic [ftt_pkg::S_USER_W-1:0]   s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot_out[3:0], fired[4], pending[5], nearest_valid[6],
    // nearest_delta[28:7], active_count[33:29], zero fill
    output logic [ftt_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tlast
);
    import ftt_pkg::*;

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    // input fields
    req_t              req;
    logic [SLOT_W-1:0] slot;
    logic [OFS_W-1:0]  offset;
    logic [FN_W-1:0]   frame_now;
    logic              in_table;
    logic [FN_W:0]     dl_sum;
    logic [FN_W-1:0]   dl_sat;
    logic              accept;

    assign req        = req_t'(s_tuser);
    assign slot       = s_tdata[3:0];
    assign offset     = s_tdata[19:4];
    assign frame_now  = s_tdata[41:20];
    assign in_table   = 32'(slot) < TIMERS;
    assign dl_sum     = (FN_W+1)'(frame_now) + (FN_W+1)'(offset);
    assign dl_sat     = dl_sum[FN_W] ? FN_MAX : dl_sum[FN_W-1:0];
    assign accept     = s_tvalid && s_tready;

    // cell row
    wave_t              chain [0:TIMERS];
    logic [TIMERS-1:0]  active_vec;
    wr_t                wr;

    genvar g;
    generate
        for (g = 0; g < TIMERS; g++)
        begin : g_cell
            ftt_cell #(.ID(g)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .wr       (wr),
                .wave_in  (chain[g]),
                .wave_out (chain[g+1]),
                .active   (active_vec[g])
            );
        end
    endgenerate

    // control state
    state_t             state_reg, state_next;
    wave_mode_t         mode_reg, mode_next;
    logic [FN_W-1:0]    cur_reg, cur_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic               held_valid_reg, held_valid_next;
    logic [IDX_W-1:0]   held_idx_reg, held_idx_next;
    wave_t              res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;

    wave_t              end_wave;
    logic               wave_end;
    logic               m_free;
    logic               start;
    wave_t              seed;
    logic [FN_W-1:0]    delta;
    logic [CNT_OUT_W-1:0] cnt_out;
    logic               pend_bit;

    assign end_wave = chain[TIMERS];
    assign wave_end = end_wave.go;
    assign m_free   = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign delta    = (res_reg.found && res_reg.deadline > cur_reg) ?
                      res_reg.deadline - cur_reg : '0;
    assign cnt_out  = (32'(res_reg.cnt) > 31) ? {CNT_OUT_W{1'b1}} : CNT_OUT_W'(res_reg.cnt);
    assign pend_bit = in_table && active_vec[IW'(slot)];

    assign chain[0] = seed;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req == REQ_NEAREST || req == REQ_FIRE || req == REQ_COUNT))
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (wave_end)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (mode_reg == WM_FIRE && res_reg.found)
                begin
                    if (!held_valid_reg || m_free)
                        state_next = ST_SCAN;
                end
                else if (m_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mode_next       = mode_reg;
        cur_next        = cur_reg;
        stamp_next      = stamp_reg;
        held_valid_next = held_valid_reg;
        held_idx_next   = held_idx_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        start           = 1'b0;
        wr              = '0;
        wr.deadline     = dl_sat;
        wr.stamp        = stamp_reg;
        wr.idx          = IDX_W'(slot);
        wr.clr_idx      = IDX_W'(slot);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cur_next = frame_now;
                    case (req)
                        REQ_SCHEDULE:
                        begin
                            if (in_table)
                            begin
                                wr.we      = 1'b1;
                                stamp_next = stamp_reg + 1'b1;
                            end
                        end
                        REQ_CANCEL:
                        begin
                            wr.clr = in_table;
                        end
                        REQ_PENDING:
                        begin
                            m_valid_next = 1'b1;
                            m_last_next  = 1'b1;
                            m_data_next  = '0;
                            m_data_next[3:0] = slot;
                            m_data_next[5]   = pend_bit;
                        end
                        REQ_NEAREST:
                        begin
                            start     = 1'b1;
                            mode_next = WM_NEAREST;
                        end
                        REQ_FIRE:
                        begin
                            start           = 1'b1;
                            mode_next       = WM_FIRE;
                            held_valid_next = 1'b0;
                        end
                        REQ_COUNT:
                        begin
                            start     = 1'b1;
                            mode_next = WM_COUNT;
                        end
                        default:
                        begin
                            start = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (wave_end)
                begin
                    res_next = end_wave;
                    // drop the picked slot before the next pass starts
                    if (end_wave.mode == WM_FIRE && end_wave.found)
                    begin
                        wr.clr     = 1'b1;
                        wr.clr_idx = end_wave.idx;
                    end
                end
            end
            ST_DONE:
            begin
                if (mode_reg == WM_FIRE && res_reg.found)
                begin
                    if (!held_valid_reg || m_free)
                    begin
                        if (held_valid_reg)
                        begin
                            m_valid_next     = 1'b1;
                            m_last_next      = 1'b0;
                            m_data_next      = '0;
                            m_data_next[3:0] = SLOT_W'(held_idx_reg);
                            m_data_next[4]   = 1'b1;
                        end
                        held_valid_next = 1'b1;
                        held_idx_next   = res_reg.idx;
                        start           = 1'b1;
                    end
                end
                else if (m_free)
                begin
                    m_valid_next    = 1'b1;
                    m_last_next     = 1'b1;
                    m_data_next     = '0;
                    held_valid_next = 1'b0;
                    case (mode_reg)
                        WM_FIRE:
                        begin
                            if (held_valid_reg)
                            begin
                                m_data_next[3:0] = SLOT_W'(held_idx_reg);
                                m_data_next[4]   = 1'b1;
                            end
                        end
                        WM_NEAREST:
                        begin
                            m_data_next[6]    = res_reg.found;
                            m_data_next[28:7] = delta;
                        end
                        default:
                        begin
                            m_data_next[33:29] = cnt_out;
                        end
                    endcase
                end
            end
            default:
            begin
                start = 1'b0;
            end
        endcase

        seed       = '0;
        seed.go    = start;
        seed.mode  = (state_reg == ST_IDLE) ? mode_next : mode_reg;
        seed.cur   = (state_reg == ST_IDLE) ? frame_now : cur_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            stamp_reg      <= '0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            mode_reg       <= WM_NEAREST;
        end
        else
        begin
            state_reg      <= state_next;
            stamp_reg      <= stamp_next;
            held_valid_reg <= held_valid_next;
            m_valid_reg    <= m_valid_next;
            mode_reg       <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        held_idx_reg <= held_idx_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: rtl/ftt_cell.sv
// ----------------------------------------------------------------------------
// ftt_cell
// one timer slot: holds its state and folds itself into the passing search
// ----------------------------------------------------------------------------
module ftt_cell #(
    parameter int ID = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ftt_pkg::wr_t   wr,
    input  ftt_pkg::wave_t wave_in,
    output ftt_pkg::wave_t wave_out,
    output logic           active
);
    import ftt_pkg::*;

    logic               active_reg;
    logic [FN_W-1:0]    deadline_reg;
    logic [STAMP_W-1:0] stamp_reg;
    wave_t              wave_reg;
    wave_t              wave_next;

    logic take;

    always_comb
    begin
        take = 1'b0;
        case (wave_in.mode)
            WM_NEAREST:
            begin
                take = active_reg && (!wave_in.found || deadline_reg < wave_in.deadline);
            end
            WM_FIRE:
            begin
                // latest deadline first, newest schedule breaks ties
                take = active_reg && (deadline_reg <= wave_in.cur) &&
                       (!wave_in.found || deadline_reg > wave_in.deadline ||
                        (deadline_reg == wave_in.deadline && stamp_reg > wave_in.stamp));
            end
            default:
            begin
                take = 1'b0;
            end
        endcase

        wave_next     = wave_in;
        wave_next.cnt = wave_in.cnt + CNT_W'(active_reg);
        if (take)
        begin
            wave_next.found    = 1'b1;
            wave_next.deadline = deadline_reg;
            wave_next.stamp    = stamp_reg;
            wave_next.idx      = IDX_W'(ID);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            wave_reg   <= '0;
        end
        else
        begin
            wave_reg <= wave_next;
            if (wr.we && wr.idx == IDX_W'(ID))
                active_reg <= 1'b1;
            else if (wr.clr && wr.clr_idx == IDX_W'(ID))
                active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.we && wr.idx == IDX_W'(ID))
        begin
            deadline_reg <= wr.deadline;
            stamp_reg    <= wr.stamp;
        end
    end

    assign wave_out = wave_reg;
    assign active   = active_reg;

endmodule

FILE: bench/tb_frame_deadline_timer_table.sv
// ----------------------------------------------------------------------------
// tb_frame_deadline_timer_table
// stream-level check of the timer table: schedules, cancels, queries and fires
// are driven, and every result is compared against a behavioral table model
// ----------------------------------------------------------------------------
module tb_frame_deadline_timer_table;

    timeunit 1ns;
    timeprecision 1ps;

    import ftt_pkg::*;

    localparam int NSLOT = 16;
    localparam logic [2:0] REQ_BAD6 = 3'd6;
    localparam logic [2:0] REQ_BAD7 = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [15:0] offset;
        logic [21:0] fn;
    } timer_req_t;

    typedef struct packed {
        logic [3:0]  slot_out;
        logic        fired;
        logic        pending;
        logic        nvalid;
        logic [21:0] ndelta;
        logic [4:0]  count;
        logic        last;
    } timer_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    // high means the item on the bus was taken and may be replaced
    logic        s_tready_q;

    frame_deadline_timer_table #(.TIMERS(NSLOT)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    timer_req_t  req_q[$];
    timer_res_t  expected_q[$];

    // table model
    logic        armed[NSLOT];
    logic [21:0] due_fn[NSLOT];
    logic [31:0] sched_stamp[NSLOT];
    logic [31:0] stamp_ctr;

    int  errors;
    int  n_sent;
    int  n_results;
    int  n_fired;
    int  src_idle_pct;
    int  sink_idle_pct;
    bit  sink_hold;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("timeout with %0d requests left, %0d results expected",
                 req_q.size(), expected_q.size());
        $display("[frame_deadline_timer_table] ERROR");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0d, want %0d (result %0d)", what, got, want, n_results);
    endtask

    function automatic timer_res_t blank_res();
        timer_res_t r;
        r = '0;
        r.last = 1'b1;
        return r;
    endfunction

    // works out the results of one accepted request and updates the table
    task automatic predict_timers(input timer_req_t r);
        timer_res_t  res;
        logic [22:0] sum;
        logic [21:0] best;
        bit          any;
        int          pick;
        int          cnt;
        res = blank_res();
        case (r.kind)
            REQ_SCHEDULE:
            begin
                sum = {1'b0, r.fn} + 23'(r.offset);
                due_fn[r.slot] = (sum > 23'(FN_MAX)) ? FN_MAX : sum[21:0];
                sched_stamp[r.slot] = stamp_ctr;
                stamp_ctr++;
                armed[r.slot] = 1'b1;
            end
            REQ_CANCEL:
                armed[r.slot] = 1'b0;
            REQ_PENDING:
            begin
                res.slot_out = r.slot;
                res.pending = armed[r.slot];
                expected_q.push_back(res);
            end
            REQ_NEAREST:
            begin
                any = 0;
                best = '0;
                for (int i = 0; i < NSLOT; i++)
                    if (armed[i] && (!any || due_fn[i] < best))
                    begin
                        best = due_fn[i];
                        any = 1;
                    end
                res.nvalid = any;
                res.ndelta = (any && best > r.fn) ? best - r.fn : '0;
                expected_q.push_back(res);
            end
            REQ_FIRE:
            begin
                cnt = 0;
                forever
                begin
                    pick = -1;
                    for (int i = 0; i < NSLOT; i++)
                    begin
                        if (!armed[i] || due_fn[i] > r.fn)
                            continue;
                        if (pick < 0 || due_fn[i] > due_fn[pick] ||
                            (due_fn[i] == due_fn[pick] && sched_stamp[i] > sched_stamp[pick]))
                            pick = i;
                    end
                    if (pick < 0)
                        break;
                    armed[pick] = 1'b0;
                    res = '0;
                    res.slot_out = pick[3:0];
                    res.fired = 1'b1;
                    expected_q.push_back(res);
                    cnt++;
                    n_fired++;
                end
                if (cnt == 0)
                    expected_q.push_back(blank_res());
                else
                    expected_q[$].last = 1'b1;
            end
            REQ_COUNT:
            begin
                cnt = 0;
                for (int i = 0; i < NSLOT; i++)
                    cnt += int'(armed[i]);
                res.count = cnt[4:0];
                expected_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic add_req(input logic [2:0] k, input int s, input int o, input int f);
        timer_req_t r;
        r.kind = k;
        r.slot = s[3:0];
        r.offset = o[15:0];
        r.fn = f[21:0];
        req_q.push_back(r);
    endtask

    // driver
    always @(negedge clk)
    begin
        timer_req_t r;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (!(s_tvalid && !s_tready_q))
            begin
                if (req_q.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    r = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= r.kind;
                    s_tdata  <= {6'd0, r.fn, r.offset, r.slot};
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // monitor: predicts at each accepted request, checks each accepted result
    always @(posedge clk)
    begin
        timer_req_t r;
        timer_res_t got;
        timer_res_t want;
        s_tready_q <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            r.kind = s_tuser;
            r.slot = s_tdata[3:0];
            r.offset = s_tdata[19:4];
            r.fn = s_tdata[41:20];
            predict_timers(r);
            n_sent++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.slot_out = m_tdata[3:0];
            got.fired = m_tdata[4];
            got.pending = m_tdata[5];
            got.nvalid = m_tdata[6];
            got.ndelta = m_tdata[28:7];
            got.count = m_tdata[33:29];
            got.last = m_tlast;
            n_results++;
            if (expected_q.size() == 0)
                report("unexpected result", m_tdata[31:0], '0);
            else
            begin
                want = expected_q.pop_front();
                if (got.slot_out != want.slot_out)
                    report("slot_out", 32'(got.slot_out), 32'(want.slot_out));
                if (got.fired != want.fired)
                    report("fired", 32'(got.fired), 32'(want.fired));
                if (got.pending != want.pending)
                    report("pending", 32'(got.pending), 32'(want.pending));
                if (got.nvalid != want.nvalid)
                    report("nearest_valid", 32'(got.nvalid), 32'(want.nvalid));
                if (got.ndelta != want.ndelta)
                    report("nearest_delta", 32'(got.ndelta), 32'(want.ndelta));
                if (got.count != want.count)
                    report("active_count", 32'(got.count), 32'(want.count));
                if (got.last != want.last)
                    report("last", 32'(got.last), 32'(want.last));
            end
        end
    end

    task automatic random_reqs(input int n);
        int base;
        int k;
        for (int i = 0; i < n; i++)
        begin
            base = $urandom_range(2715647 - 70000);
            k = $urandom_range(99);
            if (k < 35)
                add_req(REQ_SCHEDULE, $urandom_range(15),
                        ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(40),
                        ($urandom_range(9) == 0) ? $urandom_range(2715647) : 1000 + $urandom_range(40));
            else if (k < 45)
                add_req(REQ_CANCEL, $urandom_range(15), $urandom_range(65535), $urandom_range(2715647));
            else if (k < 57)
                add_req(REQ_PENDING, $urandom_range(15), $urandom_range(65535), $urandom_range(2715647));
            else if (k < 67)
                add_req(REQ_NEAREST, $urandom_range(15), $urandom_range(65535),
                        ($urandom_range(3) == 0) ? base : 1000 + $urandom_range(60));
            else if (k < 87)
                add_req(REQ_FIRE, $urandom_range(15), $urandom_range(65535),
                        ($urandom_range(5) == 0) ? $urandom_range(2715647) : 1000 + $urandom_range(60));
            else if (k < 95)
                add_req(REQ_COUNT, $urandom_range(15), $urandom_range(65535), $urandom_range(2715647));
            else
                add_req($urandom_range(1) ? REQ_BAD6 : REQ_BAD7, $urandom_range(15),
                        $urandom_range(65535), $urandom_range(2715647));
        end
    endtask

    task automatic wait_drained();
        while (req_q.size() > 0 || s_tvalid || expected_q.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    initial
    begin
        errors = 0;
        n_sent = 0;
        n_results = 0;
        n_fired = 0;
        stamp_ctr = '0;
        sink_hold = 1'b0;
        src_idle_pct = 37;
        sink_idle_pct = 79;
        for (int i = 0; i < NSLOT; i++)
        begin
            armed[i] = 1'b0;
            due_fn[i] = '0;
            sched_stamp[i] = '0;
        end
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extremes, saturation, tie order, unknown kinds
        add_req(REQ_NEAREST, 0, 0, 0);
        add_req(REQ_FIRE, 0, 0, 2715647);
        add_req(REQ_COUNT, 0, 0, 0);
        add_req(REQ_SCHEDULE, 15, 65535, 4194303);
        add_req(REQ_SCHEDULE, 0, 0, 0);
        add_req(REQ_PENDING, 15, 0, 0);
        add_req(REQ_PENDING, 7, 65535, 4194303);
        add_req(REQ_SCHEDULE, 3, 10, 100);
        add_req(REQ_SCHEDULE, 5, 10, 100);
        add_req(REQ_SCHEDULE, 9, 5, 105);
        add_req(REQ_SCHEDULE, 3, 10, 100);
        add_req(REQ_NEAREST, 0, 0, 50);
        add_req(REQ_NEAREST, 0, 0, 200);
        add_req(REQ_COUNT, 0, 0, 0);
        add_req(REQ_CANCEL, 5, 65535, 4194303);
        add_req(REQ_BAD6, 9, 1, 1);
        add_req(REQ_BAD7, 3, 1, 1);
        add_req(REQ_FIRE, 0, 0, 110);
        add_req(REQ_FIRE, 0, 0, 4194302);
        add_req(REQ_FIRE, 0, 0, 4194303);
        add_req(REQ_COUNT, 0, 0, 0);
        random_reqs(60);
        wait_drained();

        src_idle_pct = 79;
        sink_idle_pct = 37;
        for (int i = 0; i < NSLOT; i++)
            add_req(REQ_SCHEDULE, i, $urandom_range(20), 5000);
        add_req(REQ_FIRE, 0, 0, 6000);
        random_reqs(60);
        wait_drained();

        // long receiver hold-off while requests keep coming
        src_idle_pct = 0;
        sink_idle_pct = 0;
        sink_hold = 1'b1;
        random_reqs(70);
        repeat (400) @(posedge clk);
        sink_hold = 1'b0;
        wait_drained();

        $display("sent %0d requests, checked %0d results, %0d of them timer fires",
                 n_sent, n_results, n_fired);
        if (errors == 0)
            $display("[frame_deadline_timer_table] OK");
        else
            $display("[frame_deadline_timer_table] ERROR");
        $finish;
    end

endmodule
